[rtl/efg_pkg.sv]
`timescale 1ns / 1ps

package efg_pkg;

    localparam logic [1:0] CMD_WAIT   = 2'd0;
    localparam logic [1:0] CMD_NOTIFY = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    typedef enum logic [2:0] {
        STS_GRANTED = 3'd0,
        STS_BLOCKED = 3'd1,
        STS_FULL    = 3'd2,
        STS_WOKEN   = 3'd3,
        STS_DELETED = 3'd4,
        STS_NONE    = 3'd5
    } status_t;

    // results reported per input item
    localparam int unsigned MAX_RESULTS = 8;
    localparam int unsigned REP_W       = 4;
    localparam int unsigned LEFT_W      = 4;
    localparam int unsigned PORT_FLAGS  = 32;

    typedef struct packed {
        logic [7:0] task_id;
        logic       want_set;
        logic       want_all;
        logic       consume;
    } waiter_ctl_t;

endpackage

[rtl/efg_if.sv]
`timescale 1ns / 1ps

interface efg_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  task_id;
    logic        want_set;
    logic        want_all;
    logic        consume;
    logic [31:0] request_mask;
    logic        set_not_clear;
    logic [31:0] change_mask;

    modport source (
        output valid, command, task_id, want_set, want_all, consume,
               request_mask, set_not_clear, change_mask,
        input  ready
    );
    modport sink (
        input  valid, command, task_id, want_set, want_all, consume,
               request_mask, set_not_clear, change_mask,
        output ready
    );
endinterface

interface efg_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  task_id_out;
    logic [31:0] matched_flags;
    logic [31:0] current_flags;
    logic [3:0]  waiters_left;
    logic        last;

    modport source (
        output valid, status, task_id_out, matched_flags, current_flags,
               waiters_left, last,
        input  ready
    );
    modport sink (
        input  valid, status, task_id_out, matched_flags, current_flags,
               waiters_left, last,
        output ready
    );
endinterface

[rtl/efg_match.sv]
`timescale 1ns / 1ps

module efg_match #(
    parameter int FLAG_BITS = 32
) (
    input  logic [FLAG_BITS-1:0] flags,
    input  logic [FLAG_BITS-1:0] mask,
    input  efg_pkg::waiter_ctl_t ctl,
    output logic                 ok,
    output logic [FLAG_BITS-1:0] hit,
    output logic [FLAG_BITS-1:0] flags_after
);

    always_comb
    begin
        hit = ctl.want_set ? (flags & mask) : (~flags & mask);
        ok  = ctl.want_all ? (hit == mask) : (hit != '0);
        flags_after = flags;
        // consume inverts the matched bits
        if (ok && ctl.consume)
        begin
            flags_after = ctl.want_set ? (flags & ~hit) : (flags | hit);
        end
    end

endmodule

[rtl/efg_cell.sv]
`timescale 1ns / 1ps

module efg_cell #(
    parameter int FLAG_BITS = 32
) (
    input  logic                 clk,
    input  logic                 shift_en,
    input  logic                 load_en,
    input  efg_pkg::waiter_ctl_t load_ctl,
    input  logic [FLAG_BITS-1:0] load_mask,
    input  efg_pkg::waiter_ctl_t nbr_ctl,
    input  logic [FLAG_BITS-1:0] nbr_mask,
    output efg_pkg::waiter_ctl_t ctl_q,
    output logic [FLAG_BITS-1:0] mask_q
);

    efg_pkg::waiter_ctl_t ctl_reg;
    efg_pkg::waiter_ctl_t ctl_next;
    logic [FLAG_BITS-1:0] mask_reg;
    logic [FLAG_BITS-1:0] mask_next;

    always_comb
    begin
        ctl_next  = ctl_reg;
        mask_next = mask_reg;
        if (load_en)
        begin
            ctl_next  = load_ctl;
            mask_next = load_mask;
        end
        else if (shift_en)
        begin
            ctl_next  = nbr_ctl;
            mask_next = nbr_mask;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg  <= ctl_next;
        mask_reg <= mask_next;
    end

    assign ctl_q  = ctl_reg;
    assign mask_q = mask_reg;

endmodule

[rtl/event_flag_group.sv]
`timescale 1ns / 1ps
// channel   dir  handshake     payload
// req       in   valid/ready   command task_id want_set want_all consume request_mask
//                              set_not_clear change_mask
// rsp       out  valid/ready   status task_id_out matched_flags current_flags
//                              waiters_left last
// cfg       in   cfg_we        cfg_wdata (initial_flags)
//
// a wait goes from idle through finish; a notify or delete walks the stored waiters,
// one waiter leaving the head of the cell chain per cycle through the one
// match unit while rsp does not stall a second pending result, then a step
// to see the walk is done and a finish step.
// reset empties the waiter table and clears the flag word; no clearing pass.
// one result can sit in the rsp register while the next one is formed.

module event_flag_group #(
    parameter int WAITERS   = 8,
    parameter int FLAG_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    efg_in_if.sink      req,
    efg_out_if.source   rsp
);

    localparam int CNT_W = $clog2(WAITERS + 1);
    localparam int IDX_W = (WAITERS > 1) ? $clog2(WAITERS) : 1;
    localparam int REP_W = efg_pkg::REP_W;
    localparam int LEFT_W = efg_pkg::LEFT_W;
    localparam int PF = efg_pkg::PORT_FLAGS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DEL,
        S_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [FLAG_BITS-1:0] flags_reg, flags_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     steps_reg, steps_next;
    logic [REP_W-1:0]     rep_reg, rep_next;

    logic                 pend_valid_reg, pend_valid_next;
    efg_pkg::status_t     pend_status_reg, pend_status_next;
    logic [7:0]           pend_task_reg, pend_task_next;
    logic [PF-1:0]        pend_matched_reg, pend_matched_next;
    logic [PF-1:0]        pend_current_reg, pend_current_next;
    logic [LEFT_W-1:0]    pend_left_reg, pend_left_next;

    logic                 out_valid_reg, out_valid_next;
    efg_pkg::status_t     out_status_reg, out_status_next;
    logic [7:0]           out_task_reg, out_task_next;
    logic [PF-1:0]        out_matched_reg, out_matched_next;
    logic [PF-1:0]        out_current_reg, out_current_next;
    logic [LEFT_W-1:0]    out_left_reg, out_left_next;
    logic                 out_last_reg, out_last_next;

    efg_pkg::waiter_ctl_t cell_ctl [WAITERS];
    logic [FLAG_BITS-1:0] cell_mask [WAITERS];

    efg_pkg::waiter_ctl_t req_ctl;
    logic [FLAG_BITS-1:0] req_mask;
    efg_pkg::waiter_ctl_t m_ctl;
    logic [FLAG_BITS-1:0] m_mask;
    logic                 m_ok;
    logic [FLAG_BITS-1:0] m_hit;
    logic [FLAG_BITS-1:0] m_flags_after;

    logic                 shift_en;
    logic                 load_en;
    logic [IDX_W-1:0]     load_idx;
    efg_pkg::waiter_ctl_t load_ctl;
    logic [FLAG_BITS-1:0] load_mask;

    logic                 new_res;
    efg_pkg::status_t     new_status;
    logic [7:0]           new_task;
    logic [FLAG_BITS-1:0] new_matched;
    logic                 out_free;

    always_comb
    begin
        req_ctl.task_id  = req.task_id;
        req_ctl.want_set = req.want_set;
        req_ctl.want_all = req.want_all;
        req_ctl.consume  = req.consume;
    end

    assign req_mask = FLAG_BITS'(req.request_mask);

    // the match unit sees the request in idle and the chain head otherwise
    assign m_ctl  = (state_reg == S_IDLE) ? req_ctl : cell_ctl[0];
    assign m_mask = (state_reg == S_IDLE) ? req_mask : cell_mask[0];

    efg_match #(
        .FLAG_BITS (FLAG_BITS)
    ) u_match (
        .flags       (flags_reg),
        .mask        (m_mask),
        .ctl         (m_ctl),
        .ok          (m_ok),
        .hit         (m_hit),
        .flags_after (m_flags_after)
    );

    genvar gi;
    generate
        for (gi = 0; gi < WAITERS; gi++)
        begin : g_cell
            efg_pkg::waiter_ctl_t nbr_ctl;
            logic [FLAG_BITS-1:0] nbr_mask;

            if (gi == WAITERS - 1)
            begin : g_tail
                assign nbr_ctl  = '0;
                assign nbr_mask = '0;
            end
            else
            begin : g_body
                assign nbr_ctl  = cell_ctl[gi + 1];
                assign nbr_mask = cell_mask[gi + 1];
            end

            efg_cell #(
                .FLAG_BITS (FLAG_BITS)
            ) u_cell (
                .clk       (clk),
                .shift_en  (shift_en),
                .load_en   (load_en && (load_idx == IDX_W'(gi))),
                .load_ctl  (load_ctl),
                .load_mask (load_mask),
                .nbr_ctl   (nbr_ctl),
                .nbr_mask  (nbr_mask),
                .ctl_q     (cell_ctl[gi]),
                .mask_q    (cell_mask[gi])
            );
        end
    endgenerate

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        flags_next        = flags_reg;
        cnt_next          = cnt_reg;
        steps_next        = steps_reg;
        rep_next          = rep_reg;
        pend_valid_next   = pend_valid_reg;
        pend_status_next  = pend_status_reg;
        pend_task_next    = pend_task_reg;
        pend_matched_next = pend_matched_reg;
        pend_current_next = pend_current_reg;
        pend_left_next    = pend_left_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_status_next   = out_status_reg;
        out_task_next     = out_task_reg;
        out_matched_next  = out_matched_reg;
        out_current_next  = out_current_reg;
        out_left_next     = out_left_reg;
        out_last_next     = out_last_reg;

        shift_en    = 1'b0;
        load_en     = 1'b0;
        load_idx    = IDX_W'(cnt_reg);
        load_ctl    = req_ctl;
        load_mask   = req_mask;
        new_res     = 1'b0;
        new_status  = efg_pkg::STS_NONE;
        new_task    = '0;
        new_matched = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.command)
                        efg_pkg::CMD_WAIT:
                        begin
                            new_res    = 1'b1;
                            new_task   = req.task_id;
                            state_next = S_FINISH;
                            if (m_ok)
                            begin
                                new_status  = efg_pkg::STS_GRANTED;
                                new_matched = m_hit;
                                flags_next  = m_flags_after;
                            end
                            else if (cnt_reg == CNT_W'(WAITERS))
                            begin
                                new_status = efg_pkg::STS_FULL;
                            end
                            else
                            begin
                                new_status = efg_pkg::STS_BLOCKED;
                                load_en    = 1'b1;
                                cnt_next   = cnt_reg + CNT_W'(1);
                            end
                        end
                        efg_pkg::CMD_NOTIFY:
                        begin
                            if (req.set_not_clear)
                                flags_next = flags_reg | FLAG_BITS'(req.change_mask);
                            else
                                flags_next = flags_reg & ~FLAG_BITS'(req.change_mask);
                            steps_next = cnt_reg;
                            rep_next   = '0;
                            state_next = S_WALK;
                        end
                        efg_pkg::CMD_DELETE:
                        begin
                            steps_next = cnt_reg;
                            rep_next   = '0;
                            state_next = S_DEL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (steps_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    // head leaves the chain; a waiter that stays rejoins at the tail
                    shift_en   = 1'b1;
                    steps_next = steps_reg - CNT_W'(1);
                    if (m_ok)
                    begin
                        flags_next  = m_flags_after;
                        cnt_next    = cnt_reg - CNT_W'(1);
                        new_res     = 1'b1;
                        new_status  = efg_pkg::STS_WOKEN;
                        new_task    = cell_ctl[0].task_id;
                        new_matched = m_hit;
                    end
                    else
                    begin
                        load_en   = 1'b1;
                        load_idx  = IDX_W'(cnt_reg - CNT_W'(1));
                        load_ctl  = cell_ctl[0];
                        load_mask = cell_mask[0];
                    end
                end
            end
            S_DEL:
            begin
                if (steps_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    shift_en   = 1'b1;
                    steps_next = steps_reg - CNT_W'(1);
                    cnt_next   = cnt_reg - CNT_W'(1);
                    new_res    = 1'b1;
                    new_status = efg_pkg::STS_DELETED;
                    new_task   = cell_ctl[0].task_id;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_status_next  = pend_status_reg;
                        out_task_next    = pend_task_reg;
                        out_matched_next = pend_matched_reg;
                        out_current_next = pend_current_reg;
                        out_left_next    = pend_left_reg;
                        pend_valid_next  = 1'b0;
                    end
                    else
                    begin
                        out_status_next  = efg_pkg::STS_NONE;
                        out_task_next    = '0;
                        out_matched_next = '0;
                        out_current_next = PF'(flags_reg);
                        out_left_next    = LEFT_W'(cnt_reg);
                    end
                    rep_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a new result waits in pend so the final one can carry last
        if (new_res && (rep_reg < REP_W'(efg_pkg::MAX_RESULTS)))
        begin
            if (pend_valid_reg)
            begin
                out_valid_next   = 1'b1;
                out_status_next  = pend_status_reg;
                out_task_next    = pend_task_reg;
                out_matched_next = pend_matched_reg;
                out_current_next = pend_current_reg;
                out_left_next    = pend_left_reg;
                out_last_next    = 1'b0;
            end
            pend_valid_next   = 1'b1;
            pend_status_next  = new_status;
            pend_task_next    = new_task;
            pend_matched_next = PF'(new_matched);
            pend_current_next = PF'(flags_next);
            pend_left_next    = LEFT_W'(cnt_next);
            rep_next          = rep_reg + REP_W'(1);
        end

        if (cfg_we)
        begin
            flags_next = FLAG_BITS'(cfg_wdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            flags_reg        <= '0;
            cnt_reg          <= '0;
            steps_reg        <= '0;
            rep_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            pend_status_reg  <= efg_pkg::STS_NONE;
            pend_task_reg    <= '0;
            pend_matched_reg <= '0;
            pend_current_reg <= '0;
            pend_left_reg    <= '0;
            out_valid_reg    <= 1'b0;
            out_status_reg   <= efg_pkg::STS_NONE;
            out_task_reg     <= '0;
            out_matched_reg  <= '0;
            out_current_reg  <= '0;
            out_left_reg     <= '0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            flags_reg        <= flags_next;
            cnt_reg          <= cnt_next;
            steps_reg        <= steps_next;
            rep_reg          <= rep_next;
            pend_valid_reg   <= pend_valid_next;
            pend_status_reg  <= pend_status_next;
            pend_task_reg    <= pend_task_next;
            pend_matched_reg <= pend_matched_next;
            pend_current_reg <= pend_current_next;
            pend_left_reg    <= pend_left_next;
            out_valid_reg    <= out_valid_next;
            out_status_reg   <= out_status_next;
            out_task_reg     <= out_task_next;
            out_matched_reg  <= out_matched_next;
            out_current_reg  <= out_current_next;
            out_left_reg     <= out_left_next;
            out_last_reg     <= out_last_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.task_id_out   = out_task_reg;
    assign rsp.matched_flags = out_matched_reg;
    assign rsp.current_flags = out_current_reg;
    assign rsp.waiters_left  = out_left_reg;
    assign rsp.last          = out_last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(WAITERS))
        else $error("waiter count beyond table depth");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !pend_valid_reg)
        else $error("new item taken while a result is still pending");

    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK || state_reg == S_DEL) |-> steps_reg <= cnt_reg)
        else $error("walk steps exceed stored waiters");

    a_rep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rep_reg <= REP_W'(efg_pkg::MAX_RESULTS))
        else $error("too many results reported for one item");

    a_cnt_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> cnt_reg <= $past(cnt_reg))
        else $error("waiter count grew outside a wait");

endmodule
